@@ sv/gif_lzw_decoder_assert.svh @@
// Assertion macros for the GIF LZW decoder top level.
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GLD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gld_pkg.sv @@
// Types and constants of the GIF LZW decoder.
package gld_pkg;

	localparam logic [11:0] CODE_CLEAR = 12'd256;
	localparam logic [11:0] CODE_END   = 12'd257;
	localparam logic [12:0] FIRST_FREE = 13'd258;
	localparam int          STACK_SLOTS = 4096;
	localparam int          STACK_AW    = 12;
	localparam logic [3:0]  WIDTH_MIN   = 4'd9;
	localparam logic [3:0]  WIDTH_MAX   = 4'd12;

	// Register index taken from the configuration address.
	localparam logic REG_PIXEL_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_REFUSED = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_DONE    = 3'd3,
		ST_ERROR   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_CODE,
		S_WALK,
		S_LIT,
		S_COMMIT,
		S_PULL,
		S_POP
	} state_t;

	typedef enum logic [1:0] {
		PS_PREV,
		PS_SUFFIX,
		PS_WALK
	} push_src_t;

	typedef enum logic [1:0] {
		RS_CODE,
		RS_PREV,
		RS_PREFIX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WL_NONE,
		WL_CODE,
		WL_PREV,
		WL_PREFIX
	} walk_load_t;

	typedef struct packed {
		logic       latch;
		logic       len_load;
		logic       shift;
		logic       set_fail;
		logic       set_finish;
		logic       clear;
		logic       push;
		push_src_t  push_src;
		rd_sel_t    rd_sel;
		walk_load_t walk_load;
		logic       take_first;
		logic       discard;
		logic       commit;
		logic       pop_rd;
		logic       pop;
		logic       respond;
		status_t    status;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic failed;
		logic finished;
		logic depth_nz;
		logic chunk_zero;
		logic byte_zero;
		logic pixels_nz;
		logic code_done;
		logic is_end;
		logic is_clear;
		logic is_lit;
		logic is_known;
		logic is_kwk;
		logic prev_walk;
		logic walk_on;
		logic overrun;
	} stat_t;

endpackage

@@ sv/gld_in_if.sv @@
// Input channel: one push or pull item.
interface gld_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

@@ sv/gld_out_if.sv @@
// Output channel: one result item.
interface gld_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       pixel_valid;
	logic       last_pixel;
	logic [2:0] status;

	modport source (output valid, output pixel, output pixel_valid, output last_pixel,
		output status, input ready);
	modport sink (input valid, input pixel, input pixel_valid, input last_pixel,
		input status, output ready);
endinterface

@@ sv/gld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/gld_ctrl.sv @@
// Controller state machine that sequences push, chain walk and pull work.
module gld_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_func,
	output logic           in_ready,
	input  gld_pkg::stat_t stat,
	output gld_pkg::cmd_t  cmd
);

	gld_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gld_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		cmd = '0;
		cmd.push_src = gld_pkg::PS_WALK;
		cmd.rd_sel = gld_pkg::RS_CODE;
		cmd.walk_load = gld_pkg::WL_NONE;
		cmd.status = gld_pkg::ST_OK;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			gld_pkg::S_IDLE: begin
				in_ready = !stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					cmd.latch = 1'b1;
					state_d = in_func ? gld_pkg::S_PULL : gld_pkg::S_PUSH;
				end
			end
			gld_pkg::S_PUSH: begin
				cmd.respond = 1'b1;
				state_d = gld_pkg::S_IDLE;
				priority if (stat.failed) begin
					cmd.status = gld_pkg::ST_ERROR;
				end else if (stat.finished) begin
					cmd.status = gld_pkg::ST_DONE;
				end else if (stat.depth_nz) begin
					cmd.status = gld_pkg::ST_REFUSED;
				end else if (stat.chunk_zero) begin
					// Sub-block length byte; zero ends the data.
					priority if (stat.byte_zero && stat.pixels_nz) begin
						cmd.set_fail = 1'b1;
						cmd.status = gld_pkg::ST_ERROR;
					end else if (stat.byte_zero) begin
						cmd.set_finish = 1'b1;
					end else begin
						cmd.len_load = 1'b1;
					end
				end else begin
					cmd.shift = 1'b1;
					if (stat.code_done) begin
						cmd.respond = 1'b0;
						state_d = gld_pkg::S_CODE;
					end
				end
			end
			gld_pkg::S_CODE: begin
				priority if (stat.is_end) begin
					cmd.respond = 1'b1;
					state_d = gld_pkg::S_IDLE;
					if (stat.pixels_nz) begin
						cmd.set_fail = 1'b1;
						cmd.status = gld_pkg::ST_ERROR;
					end else begin
						cmd.set_finish = 1'b1;
					end
				end else if (stat.is_clear) begin
					cmd.clear = 1'b1;
					cmd.respond = 1'b1;
					state_d = gld_pkg::S_IDLE;
				end else if (stat.is_lit) begin
					cmd.walk_load = gld_pkg::WL_CODE;
					state_d = gld_pkg::S_LIT;
				end else if (stat.is_known) begin
					cmd.rd_sel = gld_pkg::RS_CODE;
					state_d = gld_pkg::S_WALK;
				end else if (stat.is_kwk) begin
					// Code not yet in the table: previous string plus its first pixel.
					cmd.push = 1'b1;
					cmd.push_src = gld_pkg::PS_PREV;
					cmd.walk_load = gld_pkg::WL_PREV;
					cmd.rd_sel = gld_pkg::RS_PREV;
					state_d = stat.prev_walk ? gld_pkg::S_WALK : gld_pkg::S_LIT;
				end else begin
					cmd.set_fail = 1'b1;
					cmd.respond = 1'b1;
					cmd.status = gld_pkg::ST_ERROR;
					state_d = gld_pkg::S_IDLE;
				end
			end
			gld_pkg::S_WALK: begin
				// One table entry per cycle: push its suffix, follow its prefix.
				cmd.push = 1'b1;
				cmd.push_src = gld_pkg::PS_SUFFIX;
				cmd.walk_load = gld_pkg::WL_PREFIX;
				cmd.rd_sel = gld_pkg::RS_PREFIX;
				state_d = stat.walk_on ? gld_pkg::S_WALK : gld_pkg::S_LIT;
			end
			gld_pkg::S_LIT: begin
				cmd.push = 1'b1;
				cmd.push_src = gld_pkg::PS_WALK;
				cmd.take_first = 1'b1;
				state_d = gld_pkg::S_COMMIT;
			end
			gld_pkg::S_COMMIT: begin
				cmd.respond = 1'b1;
				state_d = gld_pkg::S_IDLE;
				if (stat.overrun) begin
					cmd.discard = 1'b1;
					cmd.status = gld_pkg::ST_ERROR;
				end else begin
					cmd.commit = 1'b1;
				end
			end
			gld_pkg::S_PULL: begin
				cmd.respond = 1'b1;
				state_d = gld_pkg::S_IDLE;
				priority if (stat.failed) begin
					cmd.status = gld_pkg::ST_ERROR;
				end else if (stat.depth_nz) begin
					cmd.respond = 1'b0;
					cmd.pop_rd = 1'b1;
					state_d = gld_pkg::S_POP;
				end else if (stat.finished) begin
					cmd.status = gld_pkg::ST_DONE;
				end else begin
					cmd.status = gld_pkg::ST_EMPTY;
				end
			end
			gld_pkg::S_POP: begin
				cmd.pop = 1'b1;
				cmd.respond = 1'b1;
				state_d = gld_pkg::S_IDLE;
			end
			default: begin
				state_d = gld_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/gld_dp.sv @@
// Datapath: bit unpacking, decode state, string tables, pixel stack and result register.
module gld_dp #(
	parameter int DICT_ENTRIES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gld_pkg::cmd_t  cmd,
	output gld_pkg::stat_t stat,
	input  logic [7:0]     in_data_byte,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data,
	output logic [31:0]    pixel_count,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_pixel,
	output logic           out_pixel_valid,
	output logic           out_last_pixel,
	output logic [2:0]     out_status
);

	localparam int         AW = $clog2(DICT_ENTRIES);
	localparam logic [12:0] DICT_LIM = 13'(DICT_ENTRIES);

	logic [7:0]  byte_q;
	logic [31:0] pixel_count_q;
	logic [12:0] depth_q;
	logic [11:0] carry_q;
	logic [3:0]  carry_cnt_q;
	logic [7:0]  chunk_q;
	logic [3:0]  width_q;
	logic [12:0] next_q;
	logic [11:0] prev_code_q;
	logic        prev_valid_q;
	logic [7:0]  prev_first_q;
	logic [31:0] pixels_left_q;
	logic        finished_q;
	logic        failed_q;
	logic [11:0] code_q;
	logic [11:0] walk_q;
	logic [7:0]  first_q;
	logic        out_valid_q;
	logic [7:0]  pixel_q;
	logic        pvalid_q;
	logic        last_q;
	logic [2:0]  status_q;

	logic [19:0]   acc;
	logic [19:0]   acc_shr;
	logic [4:0]    cnt;
	logic [11:0]   code_mask;
	logic [11:0]   prefix_rd;
	logic [7:0]    suffix_rd;
	logic [7:0]    stack_rd;
	logic [AW-1:0] dict_raddr;
	logic          dict_we;
	logic          stack_we;
	logic [7:0]    push_data;
	logic [31:0]   pixels_dec;

	// Bit unpacking, least significant bit first.
	assign acc = 20'(carry_q) | (20'(byte_q) << carry_cnt_q);
	assign cnt = 5'(carry_cnt_q) + 5'd8;
	assign acc_shr = acc >> width_q;
	assign code_mask = ~(12'hFFF << width_q);

	// Status towards the controller.
	always_comb begin
		stat.out_busy = out_valid_q && !out_ready;
		stat.failed = failed_q;
		stat.finished = finished_q;
		stat.depth_nz = depth_q != '0;
		stat.chunk_zero = chunk_q == '0;
		stat.byte_zero = byte_q == '0;
		stat.pixels_nz = pixels_left_q != '0;
		stat.code_done = cnt >= 5'(width_q);
		stat.is_end = code_q == gld_pkg::CODE_END;
		stat.is_clear = code_q == gld_pkg::CODE_CLEAR;
		stat.is_lit = code_q[11:8] == 4'd0;
		stat.is_known = 13'(code_q) >= gld_pkg::FIRST_FREE && 13'(code_q) < next_q;
		stat.is_kwk = prev_valid_q && 13'(code_q) == next_q && next_q < DICT_LIM;
		stat.prev_walk = prev_code_q[11:8] != 4'd0 && 13'(prev_code_q) < DICT_LIM;
		stat.walk_on = prefix_rd[11:8] != 4'd0 && 13'(prefix_rd) < DICT_LIM;
		stat.overrun = 32'(depth_q) > pixels_left_q;
	end

	// Table read address.
	always_comb begin
		unique case (cmd.rd_sel)
			gld_pkg::RS_CODE:   dict_raddr = code_q[AW-1:0];
			gld_pkg::RS_PREV:   dict_raddr = prev_code_q[AW-1:0];
			gld_pkg::RS_PREFIX: dict_raddr = prefix_rd[AW-1:0];
			default:            dict_raddr = code_q[AW-1:0];
		endcase
	end

	// Pixel pushed onto the stack.
	always_comb begin
		unique case (cmd.push_src)
			gld_pkg::PS_PREV:   push_data = prev_first_q;
			gld_pkg::PS_SUFFIX: push_data = suffix_rd;
			gld_pkg::PS_WALK:   push_data = walk_q[7:0];
			default:            push_data = walk_q[7:0];
		endcase
	end

	assign dict_we = cmd.commit && prev_valid_q && next_q < DICT_LIM;
	assign stack_we = cmd.push && !depth_q[12];
	assign pixels_dec = (pixels_left_q != '0) ? pixels_left_q - 32'd1 : '0;

	gld_ram #(.WIDTH(12), .DEPTH(DICT_ENTRIES)) u_prefix (
		.clk   (clk),
		.we    (dict_we),
		.waddr (next_q[AW-1:0]),
		.wdata (prev_code_q),
		.raddr (dict_raddr),
		.rdata (prefix_rd)
	);

	gld_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (
		.clk   (clk),
		.we    (dict_we),
		.waddr (next_q[AW-1:0]),
		.wdata (first_q),
		.raddr (dict_raddr),
		.rdata (suffix_rd)
	);

	gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::STACK_SLOTS)) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (depth_q[gld_pkg::STACK_AW-1:0]),
		.wdata (push_data),
		.raddr (gld_pkg::STACK_AW'(depth_q - 13'd1)),
		.rdata (stack_rd)
	);

	// Payload of the current item and code under work.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_data_byte;
		end
		if (cmd.shift) begin
			code_q <= acc[11:0] & code_mask;
		end
		unique case (cmd.walk_load)
			gld_pkg::WL_CODE:   walk_q <= code_q;
			gld_pkg::WL_PREV:   walk_q <= prev_code_q;
			gld_pkg::WL_PREFIX: walk_q <= prefix_rd;
			default:            walk_q <= walk_q;
		endcase
		if (cmd.take_first) begin
			first_q <= walk_q[7:0];
		end
	end

	// Decode state; a configuration write restarts the decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
			depth_q <= '0;
			carry_q <= '0;
			carry_cnt_q <= '0;
			chunk_q <= '0;
			width_q <= gld_pkg::WIDTH_MIN;
			next_q <= gld_pkg::FIRST_FREE;
			prev_code_q <= '0;
			prev_valid_q <= 1'b0;
			prev_first_q <= '0;
			pixels_left_q <= '0;
			finished_q <= 1'b0;
			failed_q <= 1'b0;
		end else if (cfg_we) begin
			pixel_count_q <= cfg_data;
			depth_q <= '0;
			carry_q <= '0;
			carry_cnt_q <= '0;
			chunk_q <= '0;
			width_q <= gld_pkg::WIDTH_MIN;
			next_q <= gld_pkg::FIRST_FREE;
			prev_code_q <= '0;
			prev_valid_q <= 1'b0;
			prev_first_q <= '0;
			pixels_left_q <= cfg_data;
			finished_q <= 1'b0;
			failed_q <= 1'b0;
		end else begin
			if (cmd.set_fail) begin
				failed_q <= 1'b1;
			end
			if (cmd.set_finish) begin
				finished_q <= 1'b1;
			end
			if (cmd.len_load) begin
				chunk_q <= byte_q;
			end
			if (cmd.shift) begin
				chunk_q <= chunk_q - 8'd1;
				if (stat.code_done) begin
					carry_q <= acc_shr[11:0];
					carry_cnt_q <= 4'(cnt - 5'(width_q));
				end else begin
					carry_q <= acc[11:0];
					carry_cnt_q <= cnt[3:0];
				end
			end
			if (cmd.clear) begin
				next_q <= gld_pkg::FIRST_FREE;
				width_q <= gld_pkg::WIDTH_MIN;
				prev_valid_q <= 1'b0;
			end
			if (stack_we) begin
				depth_q <= depth_q + 13'd1;
			end
			if (cmd.discard) begin
				depth_q <= '0;
				failed_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (dict_we) begin
					next_q <= next_q + 13'd1;
					if (width_q < gld_pkg::WIDTH_MAX &&
						next_q + 13'd1 == (13'd1 << width_q)) begin
						width_q <= width_q + 4'd1;
					end
				end
				prev_code_q <= code_q;
				prev_first_q <= first_q;
				prev_valid_q <= 1'b1;
			end
			if (cmd.pop_rd) begin
				depth_q <= depth_q - 13'd1;
			end
			if (cmd.pop) begin
				pixels_left_q <= pixels_dec;
				if (pixels_dec == '0) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status_q <= cmd.status;
			if (cmd.pop) begin
				pixel_q <= stack_rd;
				pvalid_q <= 1'b1;
				last_q <= pixels_dec == '0;
			end else begin
				pixel_q <= '0;
				pvalid_q <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	assign pixel_count = pixel_count_q;
	assign out_valid = out_valid_q;
	assign out_pixel = pixel_q;
	assign out_pixel_valid = pvalid_q;
	assign out_last_pixel = last_q;
	assign out_status = status_q;

endmodule

@@ sv/gif_lzw_decoder.sv @@
// GIF LZW decoder for 8-bit pixels (minimum code size 8). Push items feed the compressed
// stream one byte at a time, sub-block length bytes included; pull items return at most
// one pixel. One item is in work at a time and its result waits in an output register;
// the next item can be taken in the same cycle as that result. A push that completes a
// code whose string is longer than one pixel walks its chain, reading one prefix and
// suffix table entry per cycle from the dictionary memories. A push is refused while
// decoded pixels wait on the stack. Writing pixel_count (byte address 0) restarts
// decoding; the tables keep their contents.
module gif_lzw_decoder #(
	parameter int DICT_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	gld_in_if.sink      in,
	gld_out_if.source   out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	gld_pkg::cmd_t  cmd;
	gld_pkg::stat_t stat;
	logic           cfg_we;
	logic [31:0]    pixel_count;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && paddr[2] == gld_pkg::REG_PIXEL_COUNT;
	assign prdata = (paddr[2] == gld_pkg::REG_PIXEL_COUNT) ? pixel_count : '0;

	gld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_func  (in.func),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gld_dp #(.DICT_ENTRIES(DICT_ENTRIES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_data_byte    (in.data_byte),
		.cfg_we          (cfg_we),
		.cfg_data        (pwdata),
		.pixel_count     (pixel_count),
		.out_valid       (out.valid),
		.out_ready       (out.ready),
		.out_pixel       (out.pixel),
		.out_pixel_valid (out.pixel_valid),
		.out_last_pixel  (out.last_pixel),
		.out_status      (out.status)
	);

	`include "gif_lzw_decoder_assert.svh"

	// An item is only taken while no result stays waiting.
	`GLD_ASSERT_SAME(a_accept_empty, in.valid && in.ready, !out.valid || out.ready, "item over result")
	// One item at a time: no second item in the cycle after acceptance.
	`GLD_ASSERT_NEXT(a_one_item, in.valid && in.ready, !in.ready, "second item taken while busy")
	// The final pixel is a real pixel with an ok status.
	`GLD_ASSERT_SAME(a_last_pixel, out.valid && out.last_pixel, out.pixel_valid && out.status == gld_pkg::ST_OK, "bad last pixel")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the GIF LZW decoder: generated streams, predictor, checks.
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [7:0]       pixel;
		logic             pixel_valid;
		logic             last_pixel;
		gld_pkg::status_t status;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	gld_in_if  in_ch ();
	gld_out_if out_ch ();

	gif_lzw_decoder i_dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Expected results in order, and the run's bookkeeping.
	pixel_result_t expected_q[$];
	int          error_count = 0;
	int          items_sent = 0;
	int          pixels_seen = 0;
	int          images_run = 0;
	int          send_gap_pct = 19;
	int          recv_gap_pct = 57;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	// Decoder state as predicted from the accepted items.
	logic [11:0] dec_prefix [4096];
	logic [7:0]  dec_suffix [4096];
	logic [7:0]  dec_stack [4096];
	int unsigned dec_depth, dec_carry, dec_carry_n, dec_chunk, dec_width, dec_next;
	int unsigned dec_prev, dec_left, dec_count;
	logic [7:0]  dec_first;
	bit          dec_prev_ok, dec_done, dec_failed;

	// Stream generator state, mirroring the table growth seen by the decoder.
	int unsigned enc_next, enc_width, enc_prev;
	bit          enc_prev_ok;
	int unsigned enc_len [4096];
	longint unsigned enc_acc;
	int unsigned enc_bits;
	logic [7:0]  code_bytes_q[$];
	logic [7:0]  stream_q[$];

	// Report one mismatch and count it.
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void restart_decoder();
		dec_depth = 0;
		dec_carry = 0;
		dec_carry_n = 0;
		dec_chunk = 0;
		dec_width = 9;
		dec_next = gld_pkg::FIRST_FREE;
		dec_prev = 0;
		dec_prev_ok = 1'b0;
		dec_first = '0;
		dec_left = dec_count;
		dec_done = 1'b0;
		dec_failed = 1'b0;
	endfunction

	function automatic void stack_pixel(input logic [7:0] v);
		if (dec_depth < 4096) begin
			dec_stack[dec_depth] = v;
			dec_depth++;
		end
	endfunction

	// Walk the chain of a code onto the stack; returns its first pixel.
	function automatic logic [7:0] unwind_code(input int unsigned c);
		int unsigned guard;
		guard = 0;
		while (c >= 256 && c < 4096 && guard < 4096) begin
			stack_pixel(dec_suffix[c]);
			c = dec_prefix[c];
			guard++;
		end
		stack_pixel(c[7:0]);
		return c[7:0];
	endfunction

	function automatic void decode_code(input int unsigned code);
		logic [7:0] first;
		if (code == gld_pkg::CODE_END) begin
			if (dec_left != 0) dec_failed = 1'b1;
			else dec_done = 1'b1;
			return;
		end
		if (code == gld_pkg::CODE_CLEAR) begin
			dec_next = gld_pkg::FIRST_FREE;
			dec_width = 9;
			dec_prev_ok = 1'b0;
			return;
		end
		if (code < 256 || (code >= gld_pkg::FIRST_FREE && code < dec_next)) begin
			first = unwind_code(code);
		end else if (dec_prev_ok && code == dec_next && dec_next < 4096) begin
			stack_pixel(dec_first);
			first = unwind_code(dec_prev);
		end else begin
			dec_failed = 1'b1;
			return;
		end
		// A string longer than the pixels still owed is dropped.
		if (dec_depth > dec_left) begin
			dec_depth = 0;
			dec_failed = 1'b1;
			return;
		end
		if (dec_prev_ok && dec_next < 4096) begin
			dec_prefix[dec_next] = dec_prev[11:0];
			dec_suffix[dec_next] = first;
			dec_next++;
			if (dec_width < 12 && dec_next == (1 << dec_width)) dec_width++;
		end
		dec_prev = code & 12'hFFF;
		dec_first = first;
		dec_prev_ok = 1'b1;
	endfunction

	function automatic gld_pkg::status_t decode_byte(input logic [7:0] b);
		int unsigned acc, cnt, code;
		if (dec_failed) return gld_pkg::ST_ERROR;
		if (dec_done) return gld_pkg::ST_DONE;
		if (dec_depth != 0) return gld_pkg::ST_REFUSED;
		if (dec_chunk == 0) begin
			if (b == 0) begin
				if (dec_left != 0) begin
					dec_failed = 1'b1;
					return gld_pkg::ST_ERROR;
				end
				dec_done = 1'b1;
				return gld_pkg::ST_OK;
			end
			dec_chunk = b;
			return gld_pkg::ST_OK;
		end
		dec_chunk--;
		acc = dec_carry | (int'(b) << dec_carry_n);
		cnt = dec_carry_n + 8;
		if (cnt >= dec_width) begin
			code = acc & ((1 << dec_width) - 1);
			acc = acc >> dec_width;
			dec_carry = acc & 12'hFFF;
			dec_carry_n = cnt - dec_width;
			decode_code(code);
		end else begin
			dec_carry = acc & 12'hFFF;
			dec_carry_n = cnt;
		end
		return dec_failed ? gld_pkg::ST_ERROR : gld_pkg::ST_OK;
	endfunction

	// Work out the result of one accepted item.
	function automatic pixel_result_t decode_item(input logic f, input logic [7:0] b);
		pixel_result_t r;
		r.pixel = '0;
		r.pixel_valid = 1'b0;
		r.last_pixel = 1'b0;
		if (f == 1'b0) begin
			r.status = decode_byte(b);
		end else if (dec_failed) begin
			r.status = gld_pkg::ST_ERROR;
		end else if (dec_depth != 0) begin
			dec_depth--;
			r.pixel = dec_stack[dec_depth];
			r.pixel_valid = 1'b1;
			if (dec_left != 0) dec_left--;
			if (dec_left == 0) begin
				r.last_pixel = 1'b1;
				dec_done = 1'b1;
			end
			r.status = gld_pkg::ST_OK;
		end else if (dec_done) begin
			r.status = gld_pkg::ST_DONE;
		end else begin
			r.status = gld_pkg::ST_EMPTY;
		end
		return r;
	endfunction

	// Offer one item after a random gap and record its expected result.
	task automatic send_item(input logic f, input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= f;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_q.push_back(decode_item(f, b));
		items_sent++;
	endtask

	// Wait until every expected result has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_pixel_count(input logic [31:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Read the register back.
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) flag_mismatch("pixel_count readback", prdata, value);
		psel <= 1'b0;
		penable <= 1'b0;
		dec_count = value;
		restart_decoder();
		enc_next = gld_pkg::FIRST_FREE;
		enc_width = 9;
		enc_prev_ok = 1'b0;
		enc_acc = 0;
		enc_bits = 0;
		code_bytes_q = {};
		images_run++;
	endtask

	// Pack one code, LSB first, at the width the decoder will use.
	function automatic void pack_code(input int unsigned code);
		enc_acc |= longint'(code) << enc_bits;
		enc_bits += enc_width;
		while (enc_bits >= 8) begin
			code_bytes_q.push_back(enc_acc[7:0]);
			enc_acc >>= 8;
			enc_bits -= 8;
		end
	endfunction

	// Pack a well-formed code and grow the generator's table as the decoder will.
	function automatic void emit_code(input int unsigned code);
		pack_code(code);
		if (code == gld_pkg::CODE_CLEAR) begin
			enc_next = gld_pkg::FIRST_FREE;
			enc_width = 9;
			enc_prev_ok = 1'b0;
			return;
		end
		if (code < 256) enc_len[code] = 1;
		if (enc_prev_ok && enc_next < 4096) begin
			enc_len[enc_next] = enc_len[enc_prev] + 1;
			enc_next++;
			if (enc_width < 12 && enc_next == (1 << enc_width)) enc_width++;
		end
		enc_prev = code;
		enc_prev_ok = 1'b1;
	endfunction

	// Random codes whose strings add up to exactly the given number of pixels.
	// With only literals asked for, no clear codes are mixed in, so the table fills.
	function automatic void gen_codes(input int unsigned pixels, input int lit_pct);
		int unsigned left, c, pick;
		int tries;
		left = pixels;
		while (left > 0) begin
			pick = $urandom_range(99);
			c = $urandom_range(255);
			if (enc_prev_ok && lit_pct < 100 && $urandom_range(99) < 3) begin
				emit_code(gld_pkg::CODE_CLEAR);
				continue;
			end
			if (pick >= lit_pct) begin
				if (enc_prev_ok && enc_next < 4096 && pick < lit_pct + 15 &&
						enc_len[enc_prev] + 1 <= left) begin
					c = enc_next;
					enc_len[c] = enc_len[enc_prev] + 1;
				end else if (enc_next > gld_pkg::FIRST_FREE) begin
					for (tries = 0; tries < 4; tries++) begin
						pick = $urandom_range(enc_next - 1, gld_pkg::FIRST_FREE);
						if (enc_len[pick] <= left) begin
							c = pick;
							break;
						end
					end
				end
			end
			if (c < 256) left -= 1;
			else left -= enc_len[c];
			emit_code(c);
		end
	endfunction

	// Cut the packed bytes into sub-blocks with their length bytes.
	function automatic void wrap_stream(input bit terminate);
		int unsigned idx, n, k;
		if (enc_bits > 0) code_bytes_q.push_back(enc_acc[7:0]);
		enc_acc = 0;
		enc_bits = 0;
		stream_q = {};
		idx = 0;
		while (idx < code_bytes_q.size()) begin
			n = code_bytes_q.size() - idx;
			if (n > 255) n = 255;
			if ($urandom_range(3) != 0) n = $urandom_range(n, 1);
			stream_q.push_back(n[7:0]);
			for (k = 0; k < n; k++) stream_q.push_back(code_bytes_q[idx + k]);
			idx += n;
		end
		if (terminate) stream_q.push_back(8'd0);
		code_bytes_q = {};
	endfunction

	// Feed the stream, pulling pixels whenever the decoder holds some.
	task automatic feed_stream();
		foreach (stream_q[i]) begin
			while (dec_depth != 0 && !dec_failed) begin
				if ($urandom_range(99) < 5) send_item(1'b0, $urandom_range(255));
				else send_item(1'b1, $urandom_range(255));
			end
			if ($urandom_range(99) < 4) send_item(1'b1, $urandom_range(255));
			send_item(1'b0, stream_q[i]);
		end
		while (dec_depth != 0 && !dec_failed) send_item(1'b1, $urandom_range(255));
		send_item(1'b1, $urandom_range(255));
	endtask

	// Pixel counts of zero and near the top of the range, end code and zero length byte on a complete image.
	task automatic test_count_extremes();
		write_pixel_count(32'd0);
		send_item(1'b1, 8'h00);
		emit_code(gld_pkg::CODE_END);
		wrap_stream(1'b1);
		feed_stream();
		send_item(1'b0, 8'hFF);
		write_pixel_count(32'd0);
		stream_q = {8'd0};
		feed_stream();
		write_pixel_count(32'd4294836225);
		gen_codes(5, 60);
		wrap_stream(1'b1);
		feed_stream();
		send_item(1'b0, 8'h5A);
	endtask

	// Literal extremes, a known code, a code defined by its own use, and a clear.
	task automatic test_known_codes();
		write_pixel_count(32'd8);
		emit_code(255);
		emit_code(0);
		emit_code(gld_pkg::FIRST_FREE);
		emit_code(gld_pkg::FIRST_FREE + 2);
		emit_code(gld_pkg::CODE_CLEAR);
		emit_code(7);
		emit_code(gld_pkg::CODE_END);
		wrap_stream(1'b1);
		feed_stream();
		send_item(1'b0, 8'hA5);
	endtask

	// Early end code, early data end and unknown codes all latch an error.
	task automatic test_error_cases();
		write_pixel_count(32'd10);
		emit_code(9);
		emit_code(gld_pkg::CODE_END);
		wrap_stream(1'b1);
		feed_stream();
		send_item(1'b0, 8'h01);
		write_pixel_count(32'd10);
		emit_code(3);
		wrap_stream(1'b1);
		feed_stream();
		write_pixel_count(32'd10);
		emit_code(gld_pkg::CODE_CLEAR);
		pack_code(gld_pkg::FIRST_FREE);
		wrap_stream(1'b0);
		feed_stream();
		write_pixel_count(32'd10);
		emit_code(1);
		pack_code(400);
		wrap_stream(1'b0);
		feed_stream();
		write_pixel_count(32'd1);
		emit_code(5);
		emit_code(6);
		wrap_stream(1'b0);
		feed_stream();
		send_item(1'b0, 8'h80);
	endtask

	// Enough codes to fill the table, then codes with the table frozen.
	task automatic test_table_full();
		write_pixel_count(32'd3900);
		gen_codes(3860, 100);
		gen_codes(40, 30);
		wrap_stream(1'b1);
		feed_stream();
	endtask

	// Random images, with some noise and truncated streams among them.
	task automatic test_random_images(input int item_target);
		int unsigned count, kind, k;
		while (items_sent < item_target) begin
			kind = $urandom_range(9);
			count = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
			write_pixel_count(count);
			if (kind == 0) begin
				stream_q = {};
				repeat ($urandom_range(30, 5)) stream_q.push_back($urandom_range(255));
			end else begin
				gen_codes(count, 45);
				if ($urandom_range(1)) emit_code(gld_pkg::CODE_END);
				wrap_stream(kind != 1);
				if (kind == 2) begin
					k = $urandom_range(stream_q.size() - 1);
					while (stream_q.size() > k) void'(stream_q.pop_back());
				end
			end
			feed_stream();
		end
	endtask

	// Receiver hold-off while the sender keeps offering, then a full pause mid-image.
	task automatic test_back_pressure();
		int unsigned half;
		write_pixel_count(32'd120);
		gen_codes(120, 40);
		wrap_stream(1'b1);
		half = stream_q.size() / 2;
		hold_req = 1'b1;
		for (int i = 0; i < stream_q.size(); i++) begin
			if (i == half) drain_results();
			while (dec_depth != 0 && !dec_failed) send_item(1'b1, 8'h00);
			send_item(1'b0, stream_q[i]);
		end
		while (dec_depth != 0 && !dec_failed) send_item(1'b1, 8'h00);
	endtask

	// Result receiver: random stalls plus an occasional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				flag_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (out_ch.pixel_valid) pixels_seen++;
				if (out_ch.status !== want.status)
					flag_mismatch("status", out_ch.status, want.status);
				if (out_ch.pixel_valid !== want.pixel_valid)
					flag_mismatch("pixel_valid", out_ch.pixel_valid, want.pixel_valid);
				if (out_ch.last_pixel !== want.last_pixel)
					flag_mismatch("last_pixel", out_ch.last_pixel, want.last_pixel);
				if (out_ch.pixel !== want.pixel)
					flag_mismatch("pixel", out_ch.pixel, want.pixel);
			end
		end
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("Timeout with %0d results outstanding", expected_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.func <= 1'b0;
		in_ch.data_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		dec_count = 0;
		restart_decoder();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_count_extremes();
		test_known_codes();
		test_error_cases();
		test_random_images(items_sent + 250);
		send_gap_pct = 57;
		recv_gap_pct = 19;
		test_back_pressure();
		test_random_images(items_sent + 250);
		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_table_full();
		test_random_images(items_sent + 100);

		drain_results();
		repeat (50) @(posedge clk);
		$display("Ran %0d images and %0d items, %0d pixels checked,", images_run, items_sent,
			pixels_seen);
		$display("including error cases, a filled code table and output back-pressure.");
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
